// ===== rtl/core/kait_pkg.sv =====
// Shared types, constants and helpers of the key alias identity table.
// Used by kait_store, kait_engine and key_alias_identity_table.
package kait_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W = 256;
   localparam int ALIAS_W = 32;
   localparam int PREFIX_W = 48;
   localparam logic [ALIAS_W-1:0] ALIAS_ALL_ONES = '1;

   typedef enum logic [1:0] {
      CMD_ASSIGN  = 2'd0,
      CMD_RESTORE = 2'd1,
      CMD_BY_ALIAS = 2'd2,
      CMD_BY_PREFIX = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_KEY   = 3'd1,
      ST_FULL      = 3'd2,
      ST_REJECT    = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_AMBIGUOUS = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2,
      S_DONE   = 2'd3
   } state_type;

   typedef struct packed {
      logic [ALIAS_W-1:0] alias_val;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef struct packed {
      cmd_type             command;
      logic [KEY_W-1:0]    key;
      logic                key_ok;
      logic [ALIAS_W-1:0]  alias_in;
      logic [6:0]          slot_index;
      logic [PREFIX_W-1:0] prefix;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ALIAS_W-1:0] alias_val;
      logic [KEY_W-1:0]   key;
   } result_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_ctl_type;

   // Starting alias: 0 and all-ones both move on to 1.
   function automatic logic [ALIAS_W-1:0] alias_start(input logic [ALIAS_W-1:0] a);
      return (a == '0 || a == ALIAS_ALL_ONES) ? ALIAS_W'(1) : a;
   endfunction

   function automatic logic [ALIAS_W-1:0] alias_next(input logic [ALIAS_W-1:0] a);
      logic [ALIAS_W-1:0] n;
      n = a + ALIAS_W'(1);
      return (n == '0 || n == ALIAS_ALL_ONES) ? ALIAS_W'(1) : n;
   endfunction

endpackage

// ===== rtl/core/kait_store.sv =====
// Entry memory of the key alias identity table: one write port, one read
// port with registered read data. Depends on kait_pkg.
module kait_store (
   input  logic                 clock,
   input  kait_pkg::mem_ctl_type ctl,
   output kait_pkg::entry_type  rd_data
);

   kait_pkg::entry_type mem [kait_pkg::TABLE_DEPTH];
   kait_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kait_engine.sv =====
// Command sequencer: scans the entry memory, resolves each command and
// appends new entries. Depends on kait_pkg and drives kait_store.
module kait_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  kait_pkg::req_type      req,
   output kait_pkg::mem_ctl_type  mem_ctl,
   input  kait_pkg::entry_type    rd_data,
   output logic                   res_valid,
   output kait_pkg::result_type   res,
   input  logic                   res_take
);

   kait_pkg::state_type state_ff, state_in;
   kait_pkg::req_type   req_ff, req_in;
   kait_pkg::result_type res_ff, res_in;
   kait_pkg::entry_type  saved_ff, saved_in;
   logic [kait_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [kait_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic [kait_pkg::ALIAS_W-1:0] cand_ff, cand_in;
   logic rvalid_ff, rvalid_in;
   logic alias_phase_ff, alias_phase_in;
   logic found_ff, found_in;

   logic accept, pre_reject, key_eq, alias_eq, pre_eq;
   logic stop_hit, restart, scan_end, full;
   logic [kait_pkg::ALIAS_W-1:0] alias_ref;

   assign accept = req_valid && req_ready;
   assign full = (32'(count_ff) >= kait_pkg::TABLE_DEPTH);
   assign pre_reject = (32'(req.slot_index) != 32'(count_ff)) || full ||
                       req.alias_in == '0 || req.alias_in == kait_pkg::ALIAS_ALL_ONES ||
                       !req.key_ok;

   assign alias_ref = (req_ff.command == kait_pkg::CMD_ASSIGN) ? cand_ff : req_ff.alias_in;
   assign key_eq   = rvalid_ff && rd_data.key == req_ff.key;
   assign alias_eq = rvalid_ff && rd_data.alias_val == alias_ref;
   assign pre_eq   = rvalid_ff &&
      rd_data.key[kait_pkg::KEY_W-1 -: kait_pkg::PREFIX_W] == req_ff.prefix;

   always_comb begin
      stop_hit = 1'b0;
      restart = 1'b0;
      case (req_ff.command)
         kait_pkg::CMD_ASSIGN: begin
            stop_hit = !alias_phase_ff && key_eq;
            restart  = alias_phase_ff && alias_eq;
         end
         kait_pkg::CMD_RESTORE:   stop_hit = key_eq || alias_eq;
         kait_pkg::CMD_BY_ALIAS:  stop_hit = alias_eq;
         kait_pkg::CMD_BY_PREFIX: stop_hit = pre_eq && found_ff;
         default: stop_hit = 1'b0;
      endcase
   end

   assign scan_end = !stop_hit && !restart && idx_ff == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kait_pkg::S_IDLE: begin
            if (accept) begin
               if ((req.command == kait_pkg::CMD_ASSIGN && !req.key_ok) ||
                   (req.command == kait_pkg::CMD_RESTORE && pre_reject)) begin
                  state_in = kait_pkg::S_DONE;
               end else begin
                  state_in = kait_pkg::S_SCAN;
               end
            end
         end
         kait_pkg::S_SCAN: begin
            if (stop_hit) begin
               state_in = kait_pkg::S_DONE;
            end else if (scan_end) begin
               state_in = kait_pkg::S_FINISH;
            end
         end
         kait_pkg::S_FINISH: begin
            if (req_ff.command == kait_pkg::CMD_ASSIGN && !alias_phase_ff && !full) begin
               state_in = kait_pkg::S_SCAN;
            end else begin
               state_in = kait_pkg::S_DONE;
            end
         end
         kait_pkg::S_DONE: begin
            if (res_take) begin
               state_in = kait_pkg::S_IDLE;
            end
         end
         default: state_in = kait_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in = req_ff;
      res_in = res_ff;
      saved_in = saved_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      cand_in = cand_ff;
      rvalid_in = 1'b0;
      alias_phase_in = alias_phase_ff;
      found_in = found_ff;
      mem_ctl = '0;
      mem_ctl.wr_addr = count_ff[kait_pkg::IDX_W-1:0];
      mem_ctl.wr_data.key = req_ff.key;
      mem_ctl.wr_data.alias_val = alias_ref;
      mem_ctl.rd_addr = idx_ff[kait_pkg::IDX_W-1:0];
      case (state_ff)
         kait_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req;
               idx_in = '0;
               alias_phase_in = 1'b0;
               found_in = 1'b0;
               cand_in = kait_pkg::alias_start(req.key[kait_pkg::KEY_W-1 -: kait_pkg::ALIAS_W]);
               res_in = '{status: (req.command == kait_pkg::CMD_ASSIGN) ?
                          kait_pkg::ST_BAD_KEY : kait_pkg::ST_REJECT,
                          alias_val: '0, key: '0};
            end
         end
         kait_pkg::S_SCAN: begin
            if (stop_hit) begin
               case (req_ff.command)
                  kait_pkg::CMD_RESTORE:
                     res_in = '{status: kait_pkg::ST_REJECT, alias_val: '0, key: '0};
                  kait_pkg::CMD_BY_PREFIX:
                     res_in = '{status: kait_pkg::ST_AMBIGUOUS, alias_val: '0, key: '0};
                  default:
                     res_in = '{status: kait_pkg::ST_OK, alias_val: rd_data.alias_val,
                                key: rd_data.key};
               endcase
            end else if (restart) begin
               // alias taken: bump candidate, rescan from slot 0
               cand_in = kait_pkg::alias_next(cand_ff);
               idx_in = '0;
            end else begin
               if (req_ff.command == kait_pkg::CMD_BY_PREFIX && pre_eq) begin
                  found_in = 1'b1;
                  saved_in = rd_data;
               end
               if (idx_ff != count_ff) begin
                  mem_ctl.rd_en = 1'b1;
                  rvalid_in = 1'b1;
                  idx_in = idx_ff + kait_pkg::CNT_W'(1);
               end
            end
         end
         kait_pkg::S_FINISH: begin
            case (req_ff.command)
               kait_pkg::CMD_ASSIGN: begin
                  if (!alias_phase_ff) begin
                     if (full) begin
                        res_in = '{status: kait_pkg::ST_FULL, alias_val: '0, key: '0};
                     end else begin
                        alias_phase_in = 1'b1;
                        idx_in = '0;
                     end
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     count_in = count_ff + kait_pkg::CNT_W'(1);
                     res_in = '{status: kait_pkg::ST_OK, alias_val: cand_ff, key: req_ff.key};
                  end
               end
               kait_pkg::CMD_RESTORE: begin
                  mem_ctl.wr_en = 1'b1;
                  count_in = count_ff + kait_pkg::CNT_W'(1);
                  res_in = '{status: kait_pkg::ST_OK, alias_val: req_ff.alias_in,
                             key: req_ff.key};
               end
               kait_pkg::CMD_BY_ALIAS:
                  res_in = '{status: kait_pkg::ST_NOT_FOUND, alias_val: '0, key: '0};
               default: begin
                  if (found_ff) begin
                     res_in = '{status: kait_pkg::ST_OK, alias_val: saved_ff.alias_val,
                                key: saved_ff.key};
                  end else begin
                     res_in = '{status: kait_pkg::ST_NOT_FOUND, alias_val: '0, key: '0};
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == kait_pkg::S_IDLE);
   assign res_valid = (state_ff == kait_pkg::S_DONE);
   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kait_pkg::S_IDLE;
         count_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rvalid_ff <= rvalid_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      saved_ff <= saved_in;
      idx_ff <= idx_in;
      cand_ff <= cand_in;
      alias_phase_ff <= alias_phase_in;
      found_ff <= found_in;
   end

endmodule

// ===== rtl/core/key_alias_identity_table.sv =====
// Key alias identity table: an append-only table of up to TABLE_DEPTH
// (256-bit key, 32-bit alias) entries held in one synchronous memory read
// one entry per cycle. One command is in work at a time. Each command
// runs a linear scan of the stored entries through the memory read port;
// an assign of a new key into a table that is not full adds a further
// scan, plus one more scan for every alias collision met on the way. An
// assign with an invalid key or a restore that fails its up-front checks
// skips the scan. A finished result sits in the output register while the
// next beat is taken. Depends on kait_pkg, kait_engine and kait_store.
module key_alias_identity_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_command,
   input  logic [63:0]  req_key_word_0,
   input  logic [63:0]  req_key_word_1,
   input  logic [63:0]  req_key_word_2,
   input  logic [63:0]  req_key_word_3,
   input  logic         req_key_ok,
   input  logic [31:0]  req_alias_in,
   input  logic [6:0]   req_slot_index,
   input  logic [47:0]  req_prefix,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_status,
   output logic [31:0]  rsp_alias_out,
   output logic [63:0]  rsp_found_key_0,
   output logic [63:0]  rsp_found_key_1,
   output logic [63:0]  rsp_found_key_2,
   output logic [63:0]  rsp_found_key_3
);

   kait_pkg::req_type     req;
   kait_pkg::mem_ctl_type mem_ctl;
   kait_pkg::entry_type   rd_data;
   kait_pkg::result_type  res, out_ff, out_in;
   logic res_valid, res_take, rsp_valid_ff, rsp_valid_in;

   assign req = '{command: kait_pkg::cmd_type'(req_command),
                  key: {req_key_word_0, req_key_word_1, req_key_word_2, req_key_word_3},
                  key_ok: req_key_ok, alias_in: req_alias_in,
                  slot_index: req_slot_index, prefix: req_prefix};

   kait_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .mem_ctl   (mem_ctl),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   kait_store u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_data (rd_data)
   );

   // load the output register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_in = out_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         out_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_alias_out   = out_ff.alias_val;
   assign rsp_found_key_0 = out_ff.key[255:192];
   assign rsp_found_key_1 = out_ff.key[191:128];
   assign rsp_found_key_2 = out_ff.key[127:64];
   assign rsp_found_key_3 = out_ff.key[63:0];

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for key_alias_identity_table: directed and random command beats
// are checked against a behavioral copy of the alias table. Depends on kait_pkg and the RTL.
module testbench;

   typedef struct {
      kait_pkg::cmd_type cmd;
      logic [255:0] key;
      logic         ok;
      logic [31:0]  ain;
      logic [6:0]   slot;
      logic [47:0]  pre;
   } cmd_beat_type;

   typedef struct {
      kait_pkg::status_type st;
      logic [31:0]  alias_val;
      logic [255:0] key;
   } reply_type;

   typedef struct {
      cmd_beat_type beat;
      reply_type    reply;
   } job_type;

   localparam int DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [63:0] req_key_word_0 = '0, req_key_word_1 = '0, req_key_word_2 = '0;
   logic [63:0] req_key_word_3 = '0;
   logic req_key_ok = 1'b0;
   logic [31:0] req_alias_in = '0;
   logic [6:0] req_slot_index = '0;
   logic [47:0] req_prefix = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [31:0] rsp_alias_out;
   logic [63:0] rsp_found_key_0, rsp_found_key_1, rsp_found_key_2, rsp_found_key_3;

   key_alias_identity_table dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the table, updated in issue order.
   logic [255:0] shadow_key[DEPTH];
   logic [31:0]  shadow_alias[DEPTH];
   int           shadow_n = 0;
   logic [47:0]  prefix_pool[4];

   job_type   pending_q[$];
   reply_type expected_q[$];
   job_type   cur_job;
   int     mode = 0;           // 0 none, 1 sender idle, 2 receiver stall, 3 both
   int     hold_req_n = 0;
   int     mismatches = 0;
   logic   req_took = 1'b0;
   int     quiet_cycles = 0;

   function automatic int key_slot(logic [255:0] k);
      for (int s = 0; s < shadow_n; s++)
         if (shadow_key[s] == k) return s;
      return -1;
   endfunction

   function automatic int alias_slot(logic [31:0] a);
      for (int s = 0; s < shadow_n; s++)
         if (shadow_alias[s] == a) return s;
      return -1;
   endfunction

   function automatic reply_type fail_reply(kait_pkg::status_type st);
      reply_type r;
      r.st = st;
      r.alias_val = '0;
      r.key = '0;
      return r;
   endfunction

   function automatic reply_type hit_reply(int s);
      reply_type r;
      r.st = kait_pkg::ST_OK;
      r.alias_val = shadow_alias[s];
      r.key = shadow_key[s];
      return r;
   endfunction

   function automatic void table_append(logic [255:0] k, logic [31:0] a);
      shadow_key[shadow_n] = k;
      shadow_alias[shadow_n] = a;
      shadow_n++;
   endfunction

   function automatic reply_type table_apply(cmd_beat_type b);
      int hit;
      int cnt;
      logic [31:0] a;
      case (b.cmd)
         kait_pkg::CMD_ASSIGN: begin
            if (!b.ok) return fail_reply(kait_pkg::ST_BAD_KEY);
            hit = key_slot(b.key);
            if (hit >= 0) return hit_reply(hit);
            if (shadow_n >= DEPTH) return fail_reply(kait_pkg::ST_FULL);
            a = b.key[255:224];
            while (a == '0 || a == kait_pkg::ALIAS_ALL_ONES || alias_slot(a) >= 0)
               a = (a == kait_pkg::ALIAS_ALL_ONES) ? 32'd1 : a + 32'd1;
            table_append(b.key, a);
            return hit_reply(shadow_n - 1);
         end
         kait_pkg::CMD_RESTORE: begin
            if (int'(b.slot) != shadow_n || shadow_n >= DEPTH || b.ain == '0 ||
                b.ain == kait_pkg::ALIAS_ALL_ONES || !b.ok || alias_slot(b.ain) >= 0 ||
                key_slot(b.key) >= 0)
               return fail_reply(kait_pkg::ST_REJECT);
            table_append(b.key, b.ain);
            return hit_reply(shadow_n - 1);
         end
         kait_pkg::CMD_BY_ALIAS: begin
            hit = alias_slot(b.ain);
            if (hit < 0) return fail_reply(kait_pkg::ST_NOT_FOUND);
            return hit_reply(hit);
         end
         default: begin
            hit = -1;
            cnt = 0;
            for (int s = 0; s < shadow_n; s++)
               if (shadow_key[s][255:208] == b.pre) begin
                  if (cnt == 0) hit = s;
                  cnt++;
               end
            if (cnt > 1) return fail_reply(kait_pkg::ST_AMBIGUOUS);
            if (hit < 0) return fail_reply(kait_pkg::ST_NOT_FOUND);
            return hit_reply(hit);
         end
      endcase
   endfunction

   task automatic issue(kait_pkg::cmd_type cmd, logic [255:0] k, logic ok,
                        logic [31:0] ain, logic [6:0] slot, logic [47:0] pre);
      job_type j;
      j.beat.cmd = cmd;
      j.beat.key = k;
      j.beat.ok = ok;
      j.beat.ain = ain;
      j.beat.slot = slot;
      j.beat.pre = pre;
      j.reply = table_apply(j.beat);
      pending_q.push_back(j);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [255:0] rnd_key();
      return {rnd64(), rnd64(), rnd64(), rnd64()};
   endfunction

   // Mix fresh keys, stored keys, keys from a few shared prefixes and keys led by a stored alias.
   function automatic logic [255:0] pick_key();
      logic [255:0] k;
      int r;
      r = $urandom_range(99);
      k = rnd_key();
      if (r < 50 && shadow_n > 0) k = shadow_key[$urandom_range(shadow_n - 1)];
      else if (r < 70) k[255:208] = prefix_pool[$urandom_range(3)];
      else if (r < 75 && shadow_n > 0)
         k[255:224] = shadow_alias[$urandom_range(shadow_n - 1)];
      return k;
   endfunction

   function automatic logic [31:0] pick_alias();
      int r;
      r = $urandom_range(99);
      if (r < 50 && shadow_n > 0) return shadow_alias[$urandom_range(shadow_n - 1)];
      if (r < 55) return '0;
      if (r < 60) return kait_pkg::ALIAS_ALL_ONES;
      return $urandom;
   endfunction

   task automatic gen_random(int n);
      int r;
      logic [255:0] k;
      logic [47:0] p;
      logic [6:0] slot;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         k = pick_key();
         if (r < 30) begin
            // mostly known keys so the table fills slowly
            if ($urandom_range(99) < 70 && shadow_n > 0)
               k = shadow_key[$urandom_range(shadow_n - 1)];
            issue(kait_pkg::CMD_ASSIGN, k, $urandom_range(99) < 92, $urandom,
                  7'($urandom), 48'(rnd64()));
         end else if (r < 40) begin
            slot = ($urandom_range(99) < 75) ? 7'(shadow_n) : 7'($urandom_range(127));
            issue(kait_pkg::CMD_RESTORE, k, $urandom_range(99) < 92, pick_alias(), slot,
                  48'(rnd64()));
         end else if (r < 70) begin
            issue(kait_pkg::CMD_BY_ALIAS, rnd_key(), 1'($urandom), pick_alias(),
                  7'($urandom), 48'(rnd64()));
         end else begin
            r = $urandom_range(99);
            if (r < 40 && shadow_n > 0) p = shadow_key[$urandom_range(shadow_n - 1)][255:208];
            else if (r < 75) p = prefix_pool[$urandom_range(3)];
            else p = 48'(rnd64());
            issue(kait_pkg::CMD_BY_PREFIX, rnd_key(), 1'($urandom), $urandom,
                  7'($urandom), p);
         end
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(posedge clock);
   endtask

   // Driver: advance on an accepted beat, hold otherwise.
   always @(negedge clock) begin
      logic busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid && !req_took;
         if (req_valid && req_took) expected_q.push_back(cur_job.reply);
         if (!busy) begin
            if (pending_q.size() != 0 &&
                !((mode == 1 && $urandom_range(99) < 68) ||
                  (mode == 3 && $urandom_range(99) < 6))) begin
               cur_job = pending_q.pop_front();
               req_valid <= 1'b1;
               req_command <= cur_job.beat.cmd;
               {req_key_word_0, req_key_word_1, req_key_word_2, req_key_word_3}
                  <= cur_job.beat.key;
               req_key_ok <= cur_job.beat.ok;
               req_alias_in <= cur_job.beat.ain;
               req_slot_index <= cur_job.beat.slot;
               req_prefix <= cur_job.beat.pre;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus an occasional long hold-off.
   always @(negedge clock) begin
      static int hold_left = 0;
      static int hold_seen = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_req_n) begin
         hold_seen = hold_req_n;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (mode == 2) begin
         rsp_ready <= $urandom_range(99) >= 68;
      end else if (mode == 3) begin
         rsp_ready <= $urandom_range(99) >= 6;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      reply_type want;
      req_took <= req_valid && req_ready;
      if (!reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat, status %0d", rsp_status);
         end else begin
            want = expected_q.pop_front();
            if (rsp_status != want.st || rsp_alias_out != want.alias_val ||
                {rsp_found_key_0, rsp_found_key_1, rsp_found_key_2, rsp_found_key_3}
                   != want.key) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: status exp %0d got %0d, alias exp %h got %h",
                           want.st, rsp_status, want.alias_val, rsp_alias_out);
                  $display("   key exp %h", want.key);
                  $display("   key got %h", {rsp_found_key_0, rsp_found_key_1,
                                             rsp_found_key_2, rsp_found_key_3});
               end
            end
         end
      end
   end

   initial begin
      logic [255:0] k;
      for (int i = 0; i < 4; i++) prefix_pool[i] = 48'(rnd64());
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part.
      issue(kait_pkg::CMD_ASSIGN, rnd_key(), 1'b0, '0, '0, '0);            // invalid key
      issue(kait_pkg::CMD_ASSIGN, '0, 1'b1, '0, '0, '0);                   // start 0 -> 1
      issue(kait_pkg::CMD_ASSIGN, '1, 1'b1, '1, '1, '1);                   // all-ones, 1 used
      k = rnd_key(); k[255:224] = 32'd2;
      issue(kait_pkg::CMD_ASSIGN, k, 1'b1, '0, '0, '0);                    // collides with 2
      issue(kait_pkg::CMD_ASSIGN, k, 1'b1, '0, '0, '0);                    // known key
      k = rnd_key(); k[255:224] = 32'hFFFF_FFFE;
      issue(kait_pkg::CMD_ASSIGN, k, 1'b1, '0, '0, '0);
      k = rnd_key(); k[255:224] = 32'hFFFF_FFFE;
      issue(kait_pkg::CMD_ASSIGN, k, 1'b1, '0, '0, '0);                    // wraps past all-ones
      k = rnd_key(); k[255:208] = prefix_pool[0];
      issue(kait_pkg::CMD_RESTORE, k, 1'b1, 32'h1234_5678, 7'(shadow_n), '0);   // good restore
      issue(kait_pkg::CMD_RESTORE, rnd_key(), 1'b1, 32'h0BAD_0001, 7'd127, '0); // wrong slot
      issue(kait_pkg::CMD_RESTORE, rnd_key(), 1'b1, '0, 7'(shadow_n), '0);      // alias 0
      issue(kait_pkg::CMD_RESTORE, rnd_key(), 1'b1, '1, 7'(shadow_n), '0);      // all-ones
      issue(kait_pkg::CMD_RESTORE, rnd_key(), 1'b0, 32'h0BAD_0002, 7'(shadow_n), '0);
      issue(kait_pkg::CMD_RESTORE, rnd_key(), 1'b1, 32'h1234_5678, 7'(shadow_n), '0);
      issue(kait_pkg::CMD_RESTORE, k, 1'b1, 32'h0BAD_0003, 7'(shadow_n), '0);   // key stored
      issue(kait_pkg::CMD_BY_ALIAS, '0, 1'b0, 32'h1234_5678, '0, '0);
      issue(kait_pkg::CMD_BY_ALIAS, '1, 1'b1, 32'h0BAD_0004, '1, '1);      // not found
      issue(kait_pkg::CMD_BY_PREFIX, '0, 1'b0, '0, '0, prefix_pool[0]);    // unique
      issue(kait_pkg::CMD_BY_PREFIX, '0, 1'b0, '0, '0, '1);                // all-ones key
      issue(kait_pkg::CMD_BY_PREFIX, '0, 1'b0, '0, '0, prefix_pool[1]);    // none
      k = rnd_key(); k[255:208] = prefix_pool[0];
      issue(kait_pkg::CMD_ASSIGN, k, 1'b1, '0, '0, '0);
      issue(kait_pkg::CMD_BY_PREFIX, '0, 1'b0, '0, '0, prefix_pool[0]);    // ambiguous
      drain();

      // Random part across idle modes.
      mode = 0;
      gen_random(300);
      hold_req_n++;                     // long receiver hold-off while sender keeps going
      drain();
      mode = 1;
      gen_random(400);
      drain();
      mode = 2;
      gen_random(400);
      drain();
      mode = 3;
      gen_random(400);
      drain();
      mode = 0;
      gen_random(100);
      drain();                          // sender pauses until every result is back
      gen_random(400);
      drain();

      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
